/* design/etd_pkg.sv */
// ----------------------------------------------------------------------------
// etd_pkg
// Shared types and constants of the energy transient detector.
// ----------------------------------------------------------------------------
package etd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ENERGY_W  = 31;
    localparam int SUM_W     = 42;
    localparam int COUNT_W   = 13;
    localparam int COOL_W    = 17;
    localparam int BLOCK_MAX = 4096;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = COEF_W + ENERGY_W;
    localparam int DIV_CNT_W = $clog2(ENERGY_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COEF_W-1:0] ATTACK_OLD   = 17'd58982;
    localparam logic [COEF_W-1:0] RELEASE_OLD  = 17'd3277;
    localparam logic [COEF_W-1:0] COEF_ONE     = 17'd65536;
    localparam logic [COEF_W-1:0] THRESH_BASE  = 17'd85197;

    localparam logic [7:0]  SENS_RESET = 8'd128;
    localparam logic [15:0] COOL_RESET = 16'd2400;

    localparam logic signed [COOL_W:0] COOL_MIN = -18'sd65536;

    typedef enum logic [0:0] {
        REG_SENSITIVITY = 1'b0,
        REG_COOLDOWN    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } in_item_t;

    typedef struct packed {
        logic                transient_fired;
        logic [ENERGY_W-1:0] block_energy;
        logic [ENERGY_W-1:0] envelope_level;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  sensitivity;
        logic [15:0] cooldown_samples;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* design/etd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// etd_cfg_regs
// APB register file: sensitivity and cooldown reload.
// ----------------------------------------------------------------------------
module etd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [etd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [etd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [etd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output etd_pkg::cfg_t                    cfg
);
    import etd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_idx;
    logic       wr_en;

    assign reg_idx = reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            REG_SENSITIVITY:
            begin
                prdata = {24'd0, cfg_reg.sensitivity};
                if (wr_en)
                begin
                    cfg_next.sensitivity = pwdata[7:0];
                end
            end
            REG_COOLDOWN:
            begin
                prdata = {16'd0, cfg_reg.cooldown_samples};
                if (wr_en)
                begin
                    cfg_next.cooldown_samples = pwdata[15:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensitivity      <= SENS_RESET;
            cfg_reg.cooldown_samples <= COOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/etd_mul_unit.sv */
// ----------------------------------------------------------------------------
// etd_mul_unit
// Shared unsigned 17x31 multiplier with registered product.
// ----------------------------------------------------------------------------
module etd_mul_unit (
    input  logic                          clk,
    input  logic [etd_pkg::COEF_W-1:0]    op_a,
    input  logic [etd_pkg::ENERGY_W-1:0]  op_b,
    output logic [etd_pkg::PROD_W-1:0]    prod
);
    import etd_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

/* design/etd_div_unit.sv */
// ----------------------------------------------------------------------------
// etd_div_unit
// Restoring divider, one quotient bit per cycle: block sum / sample count.
// ----------------------------------------------------------------------------
module etd_div_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [etd_pkg::SUM_W-1:0]     dividend,
    input  logic [etd_pkg::COUNT_W-1:0]   divisor,
    output logic [etd_pkg::ENERGY_W-1:0]  quotient,
    output etd_pkg::div_status_t          status
);
    import etd_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [ENERGY_W-1:0]  shift_reg;
    logic [ENERGY_W-1:0]  shift_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     diff;
    logic                 ge;

    // quotient < 2^31 so the top 11 dividend bits are already below the divisor
    assign trial = {rem_reg, shift_reg[ENERGY_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        step_next  = step_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            rem_next   = COUNT_W'(dividend[SUM_W-1:ENERGY_W]);
            shift_next = dividend[ENERGY_W-1:0];
            step_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            shift_next = {shift_reg[ENERGY_W-2:0], ge};
            step_next  = step_reg + DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(ENERGY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign quotient    = shift_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* design/energy_transient_detector_unit.sv */
// ----------------------------------------------------------------------------
// energy_transient_detector_unit
// Block energy onset detector: squares and sums samples, divides at block
// end, updates an attack/release envelope and fires on energy jumps.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data (sample, last_in_block)
//  out     | output    | out_valid / out_ready  | out_data (fired, energy, envelope)
//  cfg     | input     | APB psel/penable/pready| paddr, pwdata, prdata
//
//  A sample that does not close a block passes through accept, square and sum.
//  A closing sample then also runs the divider (one quotient bit per cycle) and 5
//  multiply/compare steps on the shared multiplier.
//  The result sits in an output register; a new sample is taken while it waits,
//  and the next closing block stalls only if the register is still full.
//  Reset clears the envelope, cooldown, sum and count; no clearing pass.
// ----------------------------------------------------------------------------
module energy_transient_detector_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  etd_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output etd_pkg::out_item_t               out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [etd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [etd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [etd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import etd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_MA   = 9'b000010000,
        S_MB   = 9'b000100000,
        S_MC   = 9'b001000000,
        S_MT   = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      last_reg, last_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [ENERGY_W-1:0]       env_reg, env_next;
    logic signed [COOL_W-1:0]  cool_reg, cool_next;
    logic [ENERGY_W-1:0]       energy_reg, energy_next;
    logic                      attack_reg, attack_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    cfg_t                      cfg;
    logic [COEF_W-1:0]         mul_a;
    logic [ENERGY_W-1:0]       mul_b;
    logic [PROD_W-1:0]         prod;
    logic                      div_start;
    logic [ENERGY_W-1:0]       quotient;
    div_status_t               div_st;

    logic [MAG_W-1:0]          samp_sx;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          sum_sat;
    logic [COUNT_W-1:0]        count_inc;
    logic                      block_end;
    logic [COEF_W-1:0]         old_w;
    logic [COEF_W-1:0]         factor;
    logic [PROD_W:0]           env_sum;
    logic signed [COOL_W:0]    cool_dec;
    logic                      fire;
    logic                      out_free;

    etd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    etd_mul_unit u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    etd_div_unit u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (count_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    assign samp_sx   = {in_data.sample[SAMPLE_W-1], in_data.sample};
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(prod[ENERGY_W-1:0]);
    assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign count_inc = count_reg + COUNT_W'(1);
    assign block_end = last_reg || (count_inc == COUNT_W'(BLOCK_MAX));
    assign old_w     = attack_reg ? ATTACK_OLD : RELEASE_OLD;
    assign factor    = THRESH_BASE - {3'd0, cfg.sensitivity, 6'd0};
    assign env_sum   = {1'b0, acc_reg} + {1'b0, prod} + (PROD_W + 1)'(32768);
    assign cool_dec  = {cool_reg[COOL_W-1], cool_reg} - (COOL_W + 1)'(count_reg);
    assign fire      = (env_reg != '0)
                    && ({1'b0, energy_reg, 16'd0} > prod)
                    && (cool_reg[COOL_W-1] || (cool_reg == '0));
    assign out_free  = !out_valid_reg || out_ready;
    assign div_start = (state_reg == S_ACC) && block_end;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = mag_reg;
                mul_b = ENERGY_W'(mag_reg);
            end
            S_MA:
            begin
                mul_a = old_w;
                mul_b = env_reg;
            end
            S_MB:
            begin
                mul_a = COEF_ONE - old_w;
                mul_b = energy_reg;
            end
            S_MT, S_OUT:
            begin
                mul_a = factor;
                mul_b = env_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        env_next       = env_reg;
        cool_next      = cool_reg;
        energy_next    = energy_reg;
        attack_next    = attack_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next   = in_data.sample[SAMPLE_W-1] ? (~samp_sx + MAG_W'(1))
                                                            : samp_sx;
                    last_next  = in_data.last_in_block;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next   = sum_sat;
                count_next = count_inc;
                state_next = block_end ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    energy_next = quotient;
                    attack_next = quotient > env_reg;
                    state_next  = S_MA;
                end
            end
            S_MA:
            begin
                state_next = S_MB;
            end
            S_MB:
            begin
                acc_next   = prod;
                state_next = S_MC;
            end
            S_MC:
            begin
                env_next = env_sum[ENERGY_W+15:16];
                if (!cool_reg[COOL_W-1] && (cool_reg != '0))
                begin
                    cool_next = (cool_dec < COOL_MIN) ? COOL_MIN[COOL_W-1:0]
                                                      : cool_dec[COOL_W-1:0];
                end
                state_next = S_MT;
            end
            S_MT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.transient_fired = fire;
                    out_data_next.block_energy    = energy_reg;
                    out_data_next.envelope_level  = env_reg;
                    if (fire)
                    begin
                        cool_next = COOL_W'(cfg.cooldown_samples);
                    end
                    sum_next   = '0;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            env_reg       <= '0;
            cool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            env_reg       <= env_next;
            cool_reg      <= cool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        last_reg     <= last_next;
        energy_reg   <= energy_next;
        attack_reg   <= attack_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(BLOCK_MAX))
        else $error("sample count beyond block limit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide phase");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.envelope_level <= ENERGY_W'(32'h4000_0000))
                       && (out_data_reg.block_energy <= ENERGY_W'(32'h4000_0000)))
        else $error("energy or envelope above unity");

    a_fire_reload: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free && fire)
        |=> (cool_reg == COOL_W'($past(cfg.cooldown_samples))))
        else $error("cooldown not reloaded after transient");
`endif

endmodule

/* test/energy_transient_detector_unit_tb.sv */
// ----------------------------------------------------------------------------
// energy_transient_detector_unit_tb
// Self-checking bench for the block energy onset detector. A queue-fed driver
// sends samples, and an in-bench predictor computes mean energy, envelope and
// firing for every closed block. A monitor compares each result transaction
// field by field. Random gaps and output stalls are applied across several
// register settings, extreme settings included.
// ----------------------------------------------------------------------------
module energy_transient_detector_unit_tb;

    import etd_pkg::*;

    localparam int     LATENCY     = 64;
    localparam int     THRESH_STEP = 64;
    localparam longint RUN_LIMIT   = 20000000;
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    in_item_t  sample_queue[$];
    out_item_t pending_reports[$];

    // predictor copy of the detector state and registers
    logic [7:0]        sens_cfg = SENS_RESET;
    logic [15:0]       cool_cfg = COOL_RESET;
    longint unsigned   acc_sum = 0;
    int                acc_count = 0;
    longint unsigned   env_level = 0;
    int                cool_left = 0;

    bit steady = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_wait = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int blocks_checked = 0;
    int transients_seen = 0;

    energy_transient_detector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit detector_step(input in_item_t item, output out_item_t res);
        int              s;
        longint unsigned sq;
        longint unsigned mean;
        longint unsigned wt;
        longint unsigned factor;
        bit              fired;
        s = int'(item.sample);
        sq = longint'(s) * longint'(s);
        acc_sum = acc_sum + sq;
        if (acc_sum > SUM_LIMIT)
            acc_sum = SUM_LIMIT;
        acc_count++;
        res = '0;
        if (!item.last_in_block && acc_count < BLOCK_MAX)
            return 1'b0;

        mean = acc_sum / acc_count;
        wt = (mean > env_level) ? 64'(ATTACK_OLD) : 64'(RELEASE_OLD);
        env_level = (wt * env_level + (COEF_ONE - wt) * mean + 64'd32768) >> 16;

        if (cool_left > 0)
        begin
            cool_left = cool_left - acc_count;
            if (cool_left < COOL_MIN)
                cool_left = int'(COOL_MIN);
        end

        factor = 64'(THRESH_BASE);
        factor = factor - THRESH_STEP * sens_cfg;
        fired = (env_level > 0) && ((mean << 16) > env_level * factor) && (cool_left <= 0);
        if (fired)
            cool_left = int'(cool_cfg);

        res.transient_fired = fired;
        res.block_energy    = mean[ENERGY_W-1:0];
        res.envelope_level  = env_level[ENERGY_W-1:0];
        acc_sum = 0;
        acc_count = 0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : driver
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                in_data <= sample_queue.pop_front();
                in_valid <= 1'b1;
                in_gap = steady ? 0 : $urandom_range(0, 8);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : predictor
        out_item_t res;
        if (rst_n && in_valid && in_ready)
        begin
            samples_sent++;
            if (detector_step(in_data, res))
                pending_reports.push_back(res);
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result transaction with no block closed");
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    blocks_checked++;
                    if (out_data.transient_fired)
                        transients_seen++;
                    if (out_data.transient_fired !== want.transient_fired)
                    begin
                        $error("transient_fired: expected %0d, got %0d",
                               want.transient_fired, out_data.transient_fired);
                        mismatches++;
                    end
                    if (out_data.block_energy !== want.block_energy)
                    begin
                        $error("block_energy: expected %0d, got %0d",
                               want.block_energy, out_data.block_energy);
                        mismatches++;
                    end
                    if (out_data.envelope_level !== want.envelope_level)
                    begin
                        $error("envelope_level: expected %0d, got %0d",
                               want.envelope_level, out_data.envelope_level);
                        mismatches++;
                    end
                end
                out_wait = steady ? 0 : $urandom_range(0, 8);
            end
            else if (out_wait != 0)
                out_wait--;
            out_ready <= (out_wait == 0);
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SENSITIVITY: sens_cfg = value[7:0];
            REG_COOLDOWN:    cool_cfg = value[15:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input int value, input bit last);
        in_item_t item;
        item.sample = value[SAMPLE_W-1:0];
        item.last_in_block = last;
        sample_queue.push_back(item);
    endtask

    // blocks of random length and loudness, each closed by the mark
    task automatic queue_blocks(input int n);
        int added;
        int len;
        int shift;
        logic signed [SAMPLE_W-1:0] raw;
        added = 0;
        while (added < n)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            shift = $urandom_range(0, 15);
            for (int i = 0; i < len; i++)
            begin
                raw = SAMPLE_W'($urandom);
                push_sample(int'(raw >>> shift), i == len - 1);
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || in_valid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: silence, full scale, mixed, release, cooldown hold
        push_sample(0, 1'b1);
        push_sample(32767, 1'b1);
        push_sample(-32768, 1'b0);
        push_sample(100, 1'b0);
        push_sample(-1, 1'b1);
        push_sample(0, 1'b0);
        push_sample(0, 1'b1);
        push_sample(-32768, 1'b1);
        push_sample(1, 1'b1);
        push_sample(-32767, 1'b0);
        push_sample(16384, 1'b1);
        queue_blocks(60);
        wait_drained();

        write_reg(REG_SENSITIVITY, 32'd0);
        write_reg(REG_COOLDOWN, 32'd0);
        queue_blocks(80);
        wait_drained();

        steady = 1'b1;
        write_reg(REG_SENSITIVITY, {24'($urandom_range(0, 32'hFF_FFFF)), 8'hFF});
        write_reg(REG_COOLDOWN, {16'($urandom), 16'hFFFF});
        queue_blocks(60);
        wait_drained();

        steady = 1'b0;
        write_reg(REG_SENSITIVITY, $urandom_range(0, 255));
        write_reg(REG_COOLDOWN, $urandom_range(0, 30));
        queue_blocks(100);
        wait_drained();

        write_reg(REG_SENSITIVITY, $urandom);
        write_reg(REG_COOLDOWN, {16'($urandom), 16'($urandom_range(0, 8))});
        queue_blocks(100);
        wait_drained();

        $display("covered %0d samples, %0d blocks compared, %0d transients",
                 samples_sent, blocks_checked, transients_seen);
        $display("settings: reset, zero, full scale and random; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", pending_reports.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
